// ===== hw/rtl/cdb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared types and codes for the circular deque buffer.
// ----------------------------------------------------------------------------
package cdb_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ActW    = 3;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CntOutW = 5;

  // input word: action, value_in
  localparam int unsigned InTdataW  = 40;
  // output word: status, element, count, front_value, back_value (103 bits + pad)
  localparam int unsigned OutTdataW = 104;

  localparam logic [ActW-1:0] ActPushFront = 3'd0;
  localparam logic [ActW-1:0] ActPushBack  = 3'd1;
  localparam logic [ActW-1:0] ActPopFront  = 3'd2;
  localparam logic [ActW-1:0] ActPopBack   = 3'd3;
  localparam logic [ActW-1:0] ActList      = 3'd4;

  localparam logic [StatW-1:0] StatDone  = 2'd0;
  localparam logic [StatW-1:0] StatFull  = 2'd1;
  localparam logic [StatW-1:0] StatEmpty = 2'd2;

  // packed so that status lands in the lowest bits
  typedef struct packed {
    logic signed [DataW-1:0] back_value;
    logic signed [DataW-1:0] front_value;
    logic [CntOutW-1:0]      count;
    logic signed [DataW-1:0] element;
    logic [StatW-1:0]        status;
  } result_t;

endpackage

// ===== hw/rtl/cdb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/circular_deque_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_buffer
// Bounded double-ended queue of signed 32-bit words kept in a ring RAM.
// ----------------------------------------------------------------------------
// One item is worked at a time. A push, a refused operation or an unused
// action code goes from the exec state to the response state, which loads
// the result word in the output register; a pop that leaves elements behind
// passes through a fill state first, since the new front or back word is
// fetched from the ring RAM (registered read). A list walks the RAM one
// entry per read, a read state then a word-loading state. Front and back
// words are held in registers, so results wait on the RAM only for that
// refill and the list walk. The input is ready again once the last result
// word is in the output register; a stalled output holds the sequencer.
module circular_deque_buffer
  import cdb_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,  // [2:0] action, [34:3] value_in
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [1:0] status, [33:2] element, [38:34] count, [70:39] front_value,
  // [102:71] back_value
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);

  localparam int unsigned PtrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SExec = 3'd1;
  localparam logic [2:0] SFill = 3'd2;
  localparam logic [2:0] SResp = 3'd3;
  localparam logic [2:0] SLrd  = 3'd4;
  localparam logic [2:0] SLem  = 3'd5;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    return (p == '0) ? PtrW'(CAPACITY - 1) : p - 1'b1;
  endfunction

  logic [2:0]        state_q, state_d;
  logic [ActW-1:0]   op_q;
  logic [DataW-1:0]  val_q;
  logic [PtrW-1:0]   front_slot_q, front_slot_d;
  logic [PtrW-1:0]   back_slot_q, back_slot_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [DataW-1:0]  front_val_q, front_val_d;
  logic [DataW-1:0]  back_val_q, back_val_d;
  logic [StatW-1:0]  status_q, status_d;
  logic [DataW-1:0]  elem_q, elem_d;
  logic              fill_front_q, fill_front_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;

  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic              out_last_q, out_last_d;
  logic              out_load, out_free;

  logic              mem_we, mem_re;
  logic [PtrW-1:0]   mem_waddr, mem_raddr;
  logic [DataW-1:0]  mem_rdata;

  logic              in_acc;
  logic              is_empty, is_full, list_last;
  logic [PtrW-1:0]   new_slot;

  assign s_axis_tready_o = (state_q == SIdle);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign is_empty        = (count_q == '0);
  assign is_full         = (count_q == CntW'(CAPACITY));
  assign list_last       = ((idx_q + 1'b1) == count_q);

  always_comb begin
    state_d      = state_q;
    front_slot_d = front_slot_q;
    back_slot_d  = back_slot_q;
    count_d      = count_q;
    front_val_d  = front_val_q;
    back_val_d   = back_val_q;
    status_d     = status_q;
    elem_d       = elem_q;
    fill_front_d = fill_front_q;
    idx_d        = idx_q;
    rd_ptr_d     = rd_ptr_q;
    mem_we       = 1'b0;
    mem_waddr    = front_slot_q;
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr_q;
    new_slot     = front_slot_q;
    out_load     = 1'b0;
    out_d        = out_q;
    out_last_d   = 1'b1;

    case (state_q)
      SIdle: begin
        if (in_acc) begin
          state_d = SExec;
        end
      end
      SExec: begin
        status_d = StatDone;
        elem_d   = '0;
        state_d  = SResp;
        case (op_q)
          ActPushFront: begin
            if (is_full) begin
              status_d = StatFull;
            end else begin
              new_slot     = ptr_dec(front_slot_q);
              mem_we       = 1'b1;
              mem_waddr    = new_slot;
              front_slot_d = new_slot;
              front_val_d  = val_q;
              if (is_empty) begin
                back_slot_d = new_slot;
                back_val_d  = val_q;
              end
              count_d = count_q + 1'b1;
            end
          end
          ActPushBack: begin
            if (is_full) begin
              status_d = StatFull;
            end else begin
              new_slot    = is_empty ? front_slot_q : ptr_inc(back_slot_q);
              mem_we      = 1'b1;
              mem_waddr   = new_slot;
              back_slot_d = new_slot;
              back_val_d  = val_q;
              if (is_empty) begin
                front_val_d = val_q;
              end
              count_d = count_q + 1'b1;
            end
          end
          ActPopFront: begin
            if (is_empty) begin
              status_d = StatEmpty;
            end else begin
              elem_d       = front_val_q;
              new_slot     = ptr_inc(front_slot_q);
              front_slot_d = new_slot;
              count_d      = count_q - 1'b1;
              if (count_q == CntW'(1)) begin
                front_val_d = '0;
                back_val_d  = '0;
              end else begin
                mem_re       = 1'b1;
                mem_raddr    = new_slot;
                fill_front_d = 1'b1;
                state_d      = SFill;
              end
            end
          end
          ActPopBack: begin
            if (is_empty) begin
              status_d = StatEmpty;
            end else begin
              elem_d  = back_val_q;
              count_d = count_q - 1'b1;
              if (count_q == CntW'(1)) begin
                front_val_d = '0;
                back_val_d  = '0;
              end else begin
                new_slot     = ptr_dec(back_slot_q);
                back_slot_d  = new_slot;
                mem_re       = 1'b1;
                mem_raddr    = new_slot;
                fill_front_d = 1'b0;
                state_d      = SFill;
              end
            end
          end
          ActList: begin
            if (is_empty) begin
              status_d = StatEmpty;
            end else begin
              rd_ptr_d = front_slot_q;
              idx_d    = '0;
              state_d  = SLrd;
            end
          end
          default: begin
            // unused action codes leave the queue as it is
          end
        endcase
      end
      SFill: begin
        if (fill_front_q) begin
          front_val_d = mem_rdata;
        end else begin
          back_val_d = mem_rdata;
        end
        state_d = SResp;
      end
      SResp: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.status      = status_q;
          out_d.element     = elem_q;
          out_d.count       = CntOutW'(count_q);
          out_d.front_value = front_val_q;
          out_d.back_value  = back_val_q;
          out_last_d        = 1'b1;
          state_d           = SIdle;
        end
      end
      SLrd: begin
        mem_re    = 1'b1;
        mem_raddr = rd_ptr_q;
        state_d   = SLem;
      end
      SLem: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.status      = StatDone;
          out_d.element     = mem_rdata;
          out_d.count       = CntOutW'(count_q);
          out_d.front_value = front_val_q;
          out_d.back_value  = back_val_q;
          out_last_d        = list_last;
          if (list_last) begin
            state_d = SIdle;
          end else begin
            idx_d    = idx_q + 1'b1;
            rd_ptr_d = ptr_inc(rd_ptr_q);
            state_d  = SLrd;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      front_slot_q <= '0;
      back_slot_q  <= '0;
      count_q      <= '0;
      front_val_q  <= '0;
      back_val_q   <= '0;
      fill_front_q <= 1'b0;
      idx_q        <= '0;
      rd_ptr_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_slot_q <= front_slot_d;
      back_slot_q  <= back_slot_d;
      count_q      <= count_d;
      front_val_q  <= front_val_d;
      back_val_q   <= back_val_d;
      fill_front_q <= fill_front_d;
      idx_q        <= idx_d;
      rd_ptr_q     <= rd_ptr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= s_axis_tdata_i[ActW-1:0];
      val_q <= s_axis_tdata_i[ActW +: DataW];
    end
    status_q <= status_d;
    elem_q   <= elem_d;
    if (out_load) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  cdb_ram #(
    .Width (DataW),
    .Depth (CAPACITY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (val_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutTdataW - $bits(result_t)){1'b0}}, out_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== hw/rtl/cdb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_checker
// Port-level checks for the circular deque buffer, bound to the top level.
// ----------------------------------------------------------------------------
module cdb_checker
  import cdb_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o,
  input logic                 m_axis_tlast_o
);

  logic [StatW-1:0]   st;
  logic [CntOutW-1:0] cnt;
  logic [DataW-1:0]   elem, fval, bval;

  assign st   = m_axis_tdata_o[1:0];
  assign elem = m_axis_tdata_o[33:2];
  assign cnt  = m_axis_tdata_o[38:34];
  assign fval = m_axis_tdata_o[70:39];
  assign bval = m_axis_tdata_o[102:71];

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // a refused operation gives one word only
  a_refuse_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (st == StatFull || st == StatEmpty) |-> m_axis_tlast_o)
    else $error("refused result not marked last");

  // empty status means nothing is held
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == StatEmpty |->
      cnt == '0 && fval == '0 && bval == '0 && elem == '0)
    else $error("empty result carries data");

  // full status only at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == StatFull |-> cnt == CntOutW'(CAPACITY) && elem == '0)
    else $error("full result with wrong count");

endmodule

bind circular_deque_buffer cdb_checker #(.CAPACITY(CAPACITY)) u_cdb_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circular deque buffer. Requests are driven on
// the input stream. A scoreboard keeps its own deque and predicts every word
// that comes out, list walks included. It checks those words in order. The
// input and output sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import cdb_pkg::*;

  localparam int unsigned DequeDepth = 16;
  // action codes the block does not define; it answers them with a plain done
  localparam logic [ActW-1:0] ActSpare5 = 3'd5;
  localparam logic [ActW-1:0] ActSpare6 = 3'd6;
  localparam logic [ActW-1:0] ActSpare7 = 3'd7;

  typedef struct {
    result_t word;
    logic    last;
  } reply_t;

  class deque_scoreboard;
    logic signed [DataW-1:0] slots[DequeDepth];
    int unsigned head;
    int unsigned fill;
    reply_t      replies[$];
    int unsigned mismatches;

    function new();
      head       = 0;
      fill       = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return replies.size();
    endfunction

    function void queue_reply(logic [StatW-1:0] stat, logic signed [DataW-1:0] elem,
                              logic is_last);
      reply_t r;
      r.word.status      = stat;
      r.word.element     = elem;
      r.word.count       = fill[CntOutW-1:0];
      r.word.front_value = (fill != 0) ? slots[head] : '0;
      r.word.back_value  = (fill != 0) ? slots[(head + fill - 1) % DequeDepth] : '0;
      r.last             = is_last;
      replies = {replies, r};
    endfunction

    // accepted request: update the deque and queue up the words it causes
    function void note_request(logic [ActW-1:0] act, logic signed [DataW-1:0] val);
      logic signed [DataW-1:0] popped;
      int unsigned k;
      case (act)
        ActPushFront, ActPushBack: begin
          if (fill >= DequeDepth) begin
            queue_reply(StatFull, '0, 1'b1);
          end else begin
            if (act == ActPushFront) begin
              head        = (head + DequeDepth - 1) % DequeDepth;
              slots[head] = val;
            end else begin
              slots[(head + fill) % DequeDepth] = val;
            end
            fill++;
            queue_reply(StatDone, '0, 1'b1);
          end
        end
        ActPopFront, ActPopBack: begin
          if (fill == 0) begin
            queue_reply(StatEmpty, '0, 1'b1);
          end else begin
            if (act == ActPopFront) begin
              popped = slots[head];
              head   = (head + 1) % DequeDepth;
            end else begin
              popped = slots[(head + fill - 1) % DequeDepth];
            end
            fill--;
            queue_reply(StatDone, popped, 1'b1);
          end
        end
        ActList: begin
          if (fill == 0) begin
            queue_reply(StatEmpty, '0, 1'b1);
          end else begin
            for (k = 0; k < fill; k++)
              queue_reply(StatDone, slots[(head + k) % DequeDepth], k + 1 == fill);
          end
        end
        default: queue_reply(StatDone, '0, 1'b1);
      endcase
    endfunction

    function void check_word(result_t got, logic got_last);
      reply_t want;
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected word", $realtime);
          $display("  actual:   status %0d element %0d count %0d front %0d back %0d last %0b",
                   got.status, got.element, got.count, got.front_value,
                   got.back_value, got_last);
        end
        return;
      end
      want = replies[0];
      replies.delete(0);
      if (got.status !== want.word.status || got.element !== want.word.element ||
          got.count !== want.word.count || got.front_value !== want.word.front_value ||
          got.back_value !== want.word.back_value || got_last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch", $realtime);
          $display("  expected: status %0d element %0d count %0d front %0d back %0d last %0b",
                   want.word.status, want.word.element, want.word.count,
                   want.word.front_value, want.word.back_value, want.last);
          $display("  actual:   status %0d element %0d count %0d front %0d back %0d last %0b",
                   got.status, got.element, got.count, got.front_value, got.back_value,
                   got_last);
        end
      end
    endfunction
  endclass

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [InTdataW-1:0]  s_tdata  = '0;
  logic                 m_tready = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  int unsigned     send_idle_pct = 6;
  int unsigned     rx_idle_pct   = 61;
  bit              rx_hold_now   = 1'b0;
  deque_scoreboard sb            = new();

  circular_deque_buffer #(.CAPACITY(DequeDepth)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_now) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        rx_hold_now = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      sb.check_word(result_t'(m_axis_tdata_o[$bits(result_t)-1:0]), m_axis_tlast_o);
  end

  task automatic send_request(input logic [ActW-1:0] act, input logic [DataW-1:0] val);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InTdataW-ActW-DataW){1'b0}}, val, act};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(act, val);
  endtask

  // the sender stops offering words until every expected word is back
  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mode 0 leans to pushes, 1 to pops, 2 is balanced; a new mode is drawn every 10 to 30 requests
  task automatic run_random(input int unsigned n_items);
    int unsigned i;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned r;
    int unsigned push_pct;
    logic [ActW-1:0] act;
    mode      = 0;
    mode_left = 0;
    for (i = 0; i < n_items; i++) begin
      if (i == 90) begin
        send_idle_pct = 61;
        rx_idle_pct   = 6;
      end
      if (i == 180) begin
        send_idle_pct = 0;
        rx_idle_pct   = 0;
      end
      if (i == 135) wait_drained();
      if (i == 200) rx_hold_now = 1'b1;
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(10, 30);
      end
      mode_left--;
      push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      r = $urandom_range(99);
      if (r < 3) begin
        case ($urandom_range(2))
          0:       act = ActSpare5;
          1:       act = ActSpare6;
          default: act = ActSpare7;
        endcase
      end else if (r < 11) begin
        act = ActList;
      end else if ($urandom_range(99) < push_pct) begin
        act = $urandom_range(1) ? ActPushFront : ActPushBack;
      end else begin
        act = $urandom_range(1) ? ActPopFront : ActPopBack;
      end
      send_request(act, pick_value());
    end
  endtask

  initial begin
    int unsigned k;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty-queue cases and the spare codes
    send_request(ActList, $urandom);
    send_request(ActPopFront, $urandom);
    send_request(ActPopBack, $urandom);
    send_request(ActSpare5, $urandom);
    send_request(ActSpare7, $urandom);
    // single element, then pop of the last element
    send_request(ActPushFront, 32'h7fff_ffff);
    send_request(ActPopBack, '0);
    // fill up from both ends, push into a full queue at both ends, then list it and pop the front
    send_request(ActPushBack, 32'h8000_0000);
    for (k = 1; k < DequeDepth; k++)
      send_request(k[0] ? ActPushFront : ActPushBack, $urandom);
    send_request(ActPushFront, '1);
    send_request(ActPushBack, '0);
    send_request(ActList, $urandom);
    send_request(ActPopFront, $urandom);

    run_random(243);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cdb_pkg.sv
hw/rtl/cdb_ram.sv
hw/rtl/circular_deque_buffer.sv
hw/rtl/cdb_checker.sv
verif/testbench.sv
